/* sv/ystc_pkg.sv */
`default_nettype none

package ystc_pkg;

   localparam int CHAR_W  = 8;
   localparam int TYPE_W  = 3;
   localparam int STATE_W = 6;

   // result codes of the core schema resolution
   typedef enum logic [TYPE_W-1:0] {
      TYPE_STRING = 3'd0,
      TYPE_NULL   = 3'd1,
      TYPE_BOOL   = 3'd2,
      TYPE_INT    = 3'd3,
      TYPE_UINT   = 3'd4,
      TYPE_FLOAT  = 3'd5
   } ystc_scalar_type;

   // recognizer states; the word states are named after the prefix seen so far
   // (l_ lower case, t_ title case, u_ upper case, d marks a leading dot)
   typedef enum logic [STATE_W-1:0] {
      ST_START, ST_DEAD, ST_SIGN, ST_ZERO, ST_INT, ST_PFX_O, ST_OCT, ST_PFX_X,
      ST_HEX, ST_INT_DOT, ST_FRAC, ST_DOT, ST_SDOT, ST_EXP_E, ST_EXP_SIGN,
      ST_EXP_D, ST_FWORD, ST_NULLW, ST_BOOLW,
      // null, Null, NULL
      ST_L_N, ST_L_NU, ST_L_NUL,
      ST_T_N, ST_T_NU, ST_T_NUL,
      ST_U_NU, ST_U_NUL,
      // true, True, TRUE
      ST_L_T, ST_L_TR, ST_L_TRU,
      ST_T_T, ST_T_TR, ST_T_TRU,
      ST_U_TR, ST_U_TRU,
      // false, False, FALSE
      ST_L_F, ST_L_FA, ST_L_FAL, ST_L_FALS,
      ST_T_F, ST_T_FA, ST_T_FAL, ST_T_FALS,
      ST_U_FA, ST_U_FAL, ST_U_FALS,
      // .inf, .Inf, .INF
      ST_L_DI, ST_L_DIN,
      ST_T_DI, ST_T_DIN,
      ST_U_DIN,
      // .nan, .NaN, .NAN
      ST_L_DN, ST_L_DNA,
      ST_T_DN, ST_T_DNA,
      ST_U_DNA
   } ystc_state_type;

   // one step of the recognizer for one character
   function automatic ystc_state_type ystc_next_state(input ystc_state_type s,
                                                      input logic [CHAR_W-1:0] c);
      logic dig;
      logic oct;
      logic hex;
      logic expc;
      ystc_state_type nxt;
      dig  = (c >= "0") && (c <= "9");
      oct  = (c >= "0") && (c <= "7");
      hex  = dig || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
      expc = (c == "e") || (c == "E");
      nxt  = ST_DEAD;
      unique case (s)
         ST_START: begin
            if (c == "n") nxt = ST_L_N;
            else if (c == "N") nxt = ST_T_N;
            else if (c == "t") nxt = ST_L_T;
            else if (c == "T") nxt = ST_T_T;
            else if (c == "f") nxt = ST_L_F;
            else if (c == "F") nxt = ST_T_F;
            else if (c == "~") nxt = ST_NULLW;
            else if ((c == "+") || (c == "-")) nxt = ST_SIGN;
            else if (c == "0") nxt = ST_ZERO;
            else if (c == ".") nxt = ST_DOT;
            else if (dig) nxt = ST_INT;
         end
         ST_SIGN: begin
            if (c == ".") nxt = ST_SDOT;
            else if (dig) nxt = ST_INT;
         end
         ST_ZERO: begin
            if (c == "o") nxt = ST_PFX_O;
            else if (c == "x") nxt = ST_PFX_X;
            else if (c == ".") nxt = ST_INT_DOT;
            else if (dig) nxt = ST_INT;
            else if (expc) nxt = ST_EXP_E;
         end
         ST_INT: begin
            if (c == ".") nxt = ST_INT_DOT;
            else if (dig) nxt = ST_INT;
            else if (expc) nxt = ST_EXP_E;
         end
         ST_PFX_O, ST_OCT: if (oct) nxt = ST_OCT;
         ST_PFX_X, ST_HEX: if (hex) nxt = ST_HEX;
         ST_INT_DOT, ST_FRAC: begin
            if (dig) nxt = ST_FRAC;
            else if (expc) nxt = ST_EXP_E;
         end
         ST_DOT: begin
            if (c == "i") nxt = ST_L_DI;
            else if (c == "I") nxt = ST_T_DI;
            else if (c == "n") nxt = ST_L_DN;
            else if (c == "N") nxt = ST_T_DN;
            else if (dig) nxt = ST_FRAC;
         end
         ST_SDOT: begin
            if (c == "i") nxt = ST_L_DI;
            else if (c == "I") nxt = ST_T_DI;
            else if (dig) nxt = ST_FRAC;
         end
         ST_EXP_E: begin
            if ((c == "+") || (c == "-")) nxt = ST_EXP_SIGN;
            else if (dig) nxt = ST_EXP_D;
         end
         ST_EXP_SIGN, ST_EXP_D: if (dig) nxt = ST_EXP_D;
         // null words
         ST_L_N:   if (c == "u") nxt = ST_L_NU;
         ST_L_NU:  if (c == "l") nxt = ST_L_NUL;
         ST_L_NUL: if (c == "l") nxt = ST_NULLW;
         ST_T_N: begin
            if (c == "u") nxt = ST_T_NU;
            else if (c == "U") nxt = ST_U_NU;
         end
         ST_T_NU:  if (c == "l") nxt = ST_T_NUL;
         ST_T_NUL: if (c == "l") nxt = ST_NULLW;
         ST_U_NU:  if (c == "L") nxt = ST_U_NUL;
         ST_U_NUL: if (c == "L") nxt = ST_NULLW;
         // true words
         ST_L_T:   if (c == "r") nxt = ST_L_TR;
         ST_L_TR:  if (c == "u") nxt = ST_L_TRU;
         ST_L_TRU: if (c == "e") nxt = ST_BOOLW;
         ST_T_T: begin
            if (c == "r") nxt = ST_T_TR;
            else if (c == "R") nxt = ST_U_TR;
         end
         ST_T_TR:  if (c == "u") nxt = ST_T_TRU;
         ST_T_TRU: if (c == "e") nxt = ST_BOOLW;
         ST_U_TR:  if (c == "U") nxt = ST_U_TRU;
         ST_U_TRU: if (c == "E") nxt = ST_BOOLW;
         // false words
         ST_L_F:    if (c == "a") nxt = ST_L_FA;
         ST_L_FA:   if (c == "l") nxt = ST_L_FAL;
         ST_L_FAL:  if (c == "s") nxt = ST_L_FALS;
         ST_L_FALS: if (c == "e") nxt = ST_BOOLW;
         ST_T_F: begin
            if (c == "a") nxt = ST_T_FA;
            else if (c == "A") nxt = ST_U_FA;
         end
         ST_T_FA:   if (c == "l") nxt = ST_T_FAL;
         ST_T_FAL:  if (c == "s") nxt = ST_T_FALS;
         ST_T_FALS: if (c == "e") nxt = ST_BOOLW;
         ST_U_FA:   if (c == "L") nxt = ST_U_FAL;
         ST_U_FAL:  if (c == "S") nxt = ST_U_FALS;
         ST_U_FALS: if (c == "E") nxt = ST_BOOLW;
         // infinity words
         ST_L_DI:  if (c == "n") nxt = ST_L_DIN;
         ST_L_DIN: if (c == "f") nxt = ST_FWORD;
         ST_T_DI: begin
            if (c == "n") nxt = ST_T_DIN;
            else if (c == "N") nxt = ST_U_DIN;
         end
         ST_T_DIN: if (c == "f") nxt = ST_FWORD;
         ST_U_DIN: if (c == "F") nxt = ST_FWORD;
         // not-a-number words
         ST_L_DN:  if (c == "a") nxt = ST_L_DNA;
         ST_L_DNA: if (c == "n") nxt = ST_FWORD;
         ST_T_DN: begin
            if (c == "a") nxt = ST_T_DNA;
            else if (c == "A") nxt = ST_U_DNA;
         end
         ST_T_DNA: if (c == "N") nxt = ST_FWORD;
         ST_U_DNA: if (c == "N") nxt = ST_FWORD;
         default: nxt = ST_DEAD;
      endcase
      return nxt;
   endfunction

   // type of the scalar that ends in state s
   function automatic ystc_scalar_type ystc_classify(input ystc_state_type s);
      ystc_scalar_type t;
      unique case (s)
         ST_START, ST_NULLW:                      t = TYPE_NULL;
         ST_BOOLW:                                t = TYPE_BOOL;
         ST_ZERO, ST_INT:                         t = TYPE_INT;
         ST_OCT, ST_HEX:                          t = TYPE_UINT;
         ST_INT_DOT, ST_FRAC, ST_EXP_D, ST_FWORD: t = TYPE_FLOAT;
         default:                                 t = TYPE_STRING;
      endcase
      return t;
   endfunction

endpackage

`default_nettype wire

/* sv/ystc_if.sv */
`default_nettype none

// character channel: one byte of a plain scalar per transaction
interface ystc_req_if import ystc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              has_char;
   logic              is_last;

   modport source (output valid, output char_code, output has_char, output is_last,
                   input ready);
   modport sink   (input valid, input char_code, input has_char, input is_last,
                   output ready);
endinterface

// result channel: one scalar type per transaction
interface ystc_rsp_if import ystc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TYPE_W-1:0] scalar_type;

   modport source (output valid, output scalar_type, input ready);
   modport sink   (input valid, input scalar_type, output ready);
endinterface

`default_nettype wire

/* sv/yaml_scalar_type_classifier_top.sv */
// YAML core schema scalar type classifier.
// req_chan carries the text of one plain scalar, one byte per transaction,
// with has_char marking a valid byte and is_last ending the scalar. An empty
// scalar is a single transaction with has_char low and is_last high.
// rsp_chan carries one scalar_type per scalar (0 string, 1 null, 2 bool,
// 3 int, 4 uint, 5 float); transactions without is_last give no result.
// Throughput: one transaction per cycle, sustained while rsp_chan takes its
// results. Each byte is held in an input register while the recognizer state
// register takes its step; the type of a finished scalar loads the result
// register when its last byte leaves the input register.
// When rsp_chan stalls, the result register holds and non-final bytes keep
// flowing; a second last byte waits in the input register, and req_chan.ready
// drops only while it waits.
// Reset (synchronous, active high) empties both registers and puts the
// recognizer at the start of a new scalar.
`default_nettype none

module yaml_scalar_type_classifier_top import ystc_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   ystc_req_if.sink   req_chan,
   ystc_rsp_if.source rsp_chan
);

   // input register
   logic              s1_valid_ff, s1_valid_in;
   logic [CHAR_W-1:0] s1_char_ff;
   logic              s1_has_ff;
   logic              s1_last_ff;

   // recognizer state
   ystc_state_type    state_ff, state_in;
   ystc_state_type    state_step;

   // result register
   logic              out_valid_ff, out_valid_in;
   logic [TYPE_W-1:0] out_type_ff, out_type_in;

   logic              s1_go;
   logic              req_take;

   // a non-final byte always moves on; a final one needs room in the result register
   assign s1_go          = s1_valid_ff && (!s1_last_ff || !out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_go;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign state_step = s1_has_ff ? ystc_next_state(state_ff, s1_char_ff) : state_ff;

   // next values of control and result
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      out_type_in  = out_type_ff;
      if (s1_go) s1_valid_in = 1'b0;
      if (req_take) s1_valid_in = 1'b1;
      if (out_valid_ff && rsp_chan.ready) out_valid_in = 1'b0;
      if (s1_go) begin
         if (s1_last_ff) begin
            state_in     = ST_START;
            out_valid_in = 1'b1;
            out_type_in  = ystc_classify(state_step);
         end else begin
            state_in = state_step;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         state_ff     <= ST_START;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_char_ff <= req_chan.char_code;
         s1_has_ff  <= req_chan.has_char;
         s1_last_ff <= req_chan.is_last;
      end
      out_type_ff <= out_type_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.scalar_type = out_type_ff;

   // recognizer restarts after reset
   a_reset_start: assert property (@(posedge clock)
      reset |=> state_ff == ST_START)
      else $error("recognizer not at start after reset");

   // a finished scalar leaves the recognizer at the start
   a_last_restart: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_last_ff) |=> (state_ff == ST_START && out_valid_ff))
      else $error("scalar end did not restart recognizer or raise result");

   // a waiting final byte blocks new transactions
   a_stall_block: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_last_ff && out_valid_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("input taken while final byte waits");

   // results carry a defined type code
   a_type_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_type_ff <= TYPE_FLOAT)
      else $error("result type code out of range");

endmodule

`default_nettype wire
